>>> hw/rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants for the sorted set table
// Sizes, operation and status codes, and the cell interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;

  localparam int KEY_W   = KEY_WIDTH;
  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int RANK_W  = 6;
  localparam int COUNT_W = 7;
  localparam int ELEM_W  = 32;
  localparam int IN_KEY_W = 32;
  localparam int CMP_W   = ((CNT_W > RANK_W) ? CNT_W : RANK_W) + 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic del;
  } ctl_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } ent_t;

endpackage

`default_nettype wire

>>> hw/rtl/sorted_set_table.sv
// ----------------------------------------------------------------------------
// sorted_set_table: ordered set of distinct keys in a chain of cells
// Insert, erase, query and read-by-rank on a sorted row of key cells.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | dir
//  request  | in_valid in_stall in_func in_key in_rank | in
//  result   | out_valid out_stall out_found out_count  | out
//           | out_element out_status                   |
//
// One request per cycle while in_stall is low; the result is registered and appears in the cycle after acceptance.
// The rate rests on the cell row: compare, found reduction and shift
// are all combinational. Reset empties the table at once.
// in_stall follows out_stall while a result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_set_table (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_func,
  input  wire logic [sst_pkg::IN_KEY_W-1:0]  in_key,
  input  wire logic [sst_pkg::RANK_W-1:0]    in_rank,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_found,
  output logic [sst_pkg::COUNT_W-1:0]        out_count,
  output logic [sst_pkg::ELEM_W-1:0]         out_element,
  output logic [1:0]                         out_status
);

  localparam int N = sst_pkg::CAPACITY;

  sst_pkg::op_t               op;
  logic                       in_acc;
  logic [sst_pkg::KEY_W-1:0]  k;
  sst_pkg::ent_t              ents [N];
  logic [N-1:0]               belows;
  logic [N-1:0]               eqs;
  logic [N-1:0]               valids;
  logic [sst_pkg::KEY_W-1:0]  rds [N];
  logic [sst_pkg::KEY_W-1:0]  rd_or;
  logic                       present;
  logic                       full;
  logic                       in_range;
  sst_pkg::ctl_t              ctl;

  logic [sst_pkg::CNT_W-1:0]  held_r, held_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       found_r, found_nxt;
  logic [sst_pkg::ELEM_W-1:0] elem_r, elem_nxt;
  sst_pkg::status_t           status_r, status_nxt;

  assign op       = sst_pkg::op_t'(in_func);
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign k        = sst_pkg::KEY_W'(in_key);
  assign present  = |eqs;
  assign full     = (held_r == sst_pkg::CNT_W'(N));
  assign in_range = sst_pkg::CMP_W'(in_rank) < sst_pkg::CMP_W'(held_r);

  assign ctl.ins = in_acc && (op == sst_pkg::OP_INSERT) && !present && !full;
  assign ctl.del = in_acc && (op == sst_pkg::OP_ERASE) && present;

  for (genvar i = 0; i < N; i++) begin : g_cell
    sst_pkg::ent_t prev_e, next_e;
    logic          prev_b;
    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_b = 1'b0;
    end else begin : g_mid
      assign prev_e = ents[i-1];
      assign prev_b = belows[i-1];
    end
    if (i == N - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = ents[i+1];
    end
    sst_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .idx        (sst_pkg::IDX_W'(i)),
      .key        (k),
      .rank       (in_rank),
      .ctl        (ctl),
      .prev_ent   (prev_e),
      .prev_below (prev_b),
      .next_ent   (next_e),
      .ent        (ents[i]),
      .below      (belows[i]),
      .eq         (eqs[i]),
      .rd_data    (rds[i])
    );
    assign valids[i] = ents[i].valid;
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < N; i++) begin
      rd_or = rd_or | rds[i];
    end
  end

  always_comb begin
    held_nxt = held_r;
    if (ctl.ins) begin
      held_nxt = held_r + 1'b1;
    end else if (ctl.del) begin
      held_nxt = held_r - 1'b1;
    end
  end

  always_comb begin
    found_nxt  = found_r;
    elem_nxt   = elem_r;
    status_nxt = status_r;
    if (in_acc) begin
      found_nxt  = 1'b0;
      elem_nxt   = '0;
      status_nxt = sst_pkg::ST_OK;
      unique case (op)
        sst_pkg::OP_INSERT: begin
          found_nxt = present;
          if (!present && full) begin
            status_nxt = sst_pkg::ST_FULL;
          end
        end
        sst_pkg::OP_ERASE, sst_pkg::OP_QUERY: begin
          found_nxt = present;
        end
        sst_pkg::OP_READ: begin
          if (in_range) begin
            elem_nxt = sst_pkg::ELEM_W'(rd_or);
          end else begin
            status_nxt = sst_pkg::ST_RANGE;
          end
        end
        default: begin
          found_nxt = 1'b0;
        end
      endcase
    end
  end

  assign out_valid_nxt = in_acc ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r  <= found_nxt;
    elem_r   <= elem_nxt;
    status_r <= status_nxt;
  end

  logic [sst_pkg::CNT_W-1:0] count_r;
  always_ff @(posedge clk) begin
    if (in_acc) begin
      count_r <= held_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_found   = found_r;
  assign out_count   = sst_pkg::COUNT_W'(count_r);
  assign out_element = elem_r;
  assign out_status  = status_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= sst_pkg::CNT_W'(N))
    else $error("held count beyond capacity");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valids) == int'(held_r))
    else $error("cell valid bits disagree with held count");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> held_r == $past(held_r) + 1'b1)
    else $error("insert did not grow the table");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted request produced no result");

endmodule

`default_nettype wire

>>> hw/rtl/sst_cell.sv
// ----------------------------------------------------------------------------
// sst_cell: one slot of the sorted set table
// Holds one key, compares it against the request key and takes its next
// value from itself, the request, or a neighbor on insert/erase shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [sst_pkg::IDX_W-1:0]  idx,
  input  wire logic [sst_pkg::KEY_W-1:0]  key,
  input  wire logic [sst_pkg::RANK_W-1:0] rank,
  input  wire sst_pkg::ctl_t              ctl,
  input  wire sst_pkg::ent_t              prev_ent,
  input  wire logic                       prev_below,
  input  wire sst_pkg::ent_t              next_ent,
  output sst_pkg::ent_t                   ent,
  output logic                            below,
  output logic                            eq,
  output logic [sst_pkg::KEY_W-1:0]       rd_data
);

  logic                      valid_r, valid_nxt;
  logic [sst_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                      is_pos;
  logic                      rank_hit;

  assign below    = valid_r && (key_r < key);
  assign is_pos   = !below && (idx == '0 || prev_below);
  assign eq       = is_pos && valid_r && (key_r == key);
  assign rank_hit = (sst_pkg::CMP_W'(idx) == sst_pkg::CMP_W'(rank)) && valid_r;
  assign rd_data  = rank_hit ? key_r : '0;
  assign ent      = '{valid: valid_r, key: key_r};

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    if (ctl.ins && !below) begin
      if (is_pos) begin
        valid_nxt = 1'b1;
        key_nxt   = key;
      end else begin
        valid_nxt = prev_ent.valid;
        key_nxt   = prev_ent.key;
      end
    end else if (ctl.del && !below) begin
      valid_nxt = next_ent.valid;
      key_nxt   = next_ent.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

`default_nettype wire

>>> sim/sorted_set_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_table_test: self-checking bench for the sorted set table
// Drives insert, erase, query and read-by-rank requests with random gaps and
// result back-pressure, predicts every result from a behavioral copy of the
// key set, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------

module sorted_set_table_test;

  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    sst_pkg::op_t func;
    logic [31:0]  key;
    logic [5:0]   rank;
  } req_t;

  typedef struct {
    logic             found;
    logic [6:0]       count;
    logic [31:0]      element;
    sst_pkg::status_t status;
  } res_t;

  typedef enum int {MIX_FILL, MIX_MIXED, MIX_DRAIN} mix_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  sst_pkg::op_t in_func = sst_pkg::OP_QUERY;
  logic [31:0]  in_key = '0;
  logic [5:0]   in_rank = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic         out_found;
  logic [6:0]   out_count;
  logic [31:0]  out_element;
  logic [1:0]   out_status;

  req_t        pending_reqs[$];
  res_t        expected_results[$];
  logic [31:0] used_keys[$];

  logic [31:0] set_keys[sst_pkg::CAPACITY];
  int          set_size = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int gen_count = 0;
  int errors = 0;
  int n_req = 0;
  int n_res = 0;
  int n_full = 0;
  int n_range = 0;
  int peak_count = 0;

  sorted_set_table DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_key     (in_key),
    .in_rank    (in_rank),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_found  (out_found),
    .out_count  (out_count),
    .out_element(out_element),
    .out_status (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // behavioral set: applies one request and returns its result
  function automatic res_t apply_request(input req_t r);
    res_t res;
    int   pos;
    bit   present;
    res.found = 1'b0;
    res.element = '0;
    res.status = sst_pkg::ST_OK;
    if (r.func == sst_pkg::OP_READ) begin
      if (int'(r.rank) < set_size) begin
        res.element = set_keys[r.rank];
      end else begin
        res.status = sst_pkg::ST_RANGE;
      end
    end else begin
      pos = 0;
      while (pos < set_size && set_keys[pos] < r.key) pos++;
      present = (pos < set_size) && (set_keys[pos] == r.key);
      res.found = present;
      if (r.func == sst_pkg::OP_INSERT && !present) begin
        if (set_size >= sst_pkg::CAPACITY) begin
          res.status = sst_pkg::ST_FULL;
        end else begin
          for (int i = set_size; i > pos; i--) set_keys[i] = set_keys[i-1];
          set_keys[pos] = r.key;
          set_size++;
        end
      end else if (r.func == sst_pkg::OP_ERASE && present) begin
        for (int i = pos; i + 1 < set_size; i++) set_keys[i] = set_keys[i+1];
        set_size--;
      end
    end
    res.count = set_size[6:0];
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_request('{in_func, in_key, in_rank}));
        n_req++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_func  <= pending_reqs[0].func;
          in_key   <= pending_reqs[0].key;
          in_rank  <= pending_reqs[0].rank;
          in_valid <= 1'b1;
          void'(pending_reqs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t exp_res;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          n_res++;
          if (exp_res.status == sst_pkg::ST_FULL) n_full++;
          if (exp_res.status == sst_pkg::ST_RANGE) n_range++;
          if (exp_res.count > peak_count) peak_count = exp_res.count;
          if (out_found !== exp_res.found) begin
            $error("found: expected %0h actual %0h", exp_res.found, out_found);
            errors++;
          end
          if (out_count !== exp_res.count) begin
            $error("count: expected %0d actual %0d", exp_res.count, out_count);
            errors++;
          end
          if (out_element !== exp_res.element) begin
            $error("element: expected %08h actual %08h", exp_res.element, out_element);
            errors++;
          end
          if (out_status !== exp_res.status) begin
            $error("status: expected %0d actual %0d", exp_res.status, out_status);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // watchdog
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else if (rst_n && (pending_reqs.size() != 0 || in_valid ||
                             expected_results.size() != 0)) begin
        quiet++;
      end
    end
    $display("sorted_set_table verification failed");
    $finish;
  end

  function automatic logic [31:0] fresh_key();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(0, 63);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(input sst_pkg::op_t f, input logic [31:0] k, input logic [5:0] r);
    req_t q;
    q.func = f;
    q.key  = k;
    q.rank = r;
    pending_reqs.push_back(q);
  endtask

  // random requests in blocks that fill, mix and drain the table
  task automatic add_random(input int n);
    mix_t         mix;
    int           roll;
    int           idx;
    sst_pkg::op_t f;
    logic [31:0]  k;
    logic [5:0]   r;
    for (int j = 0; j < n; j++) begin
      case ((gen_count / 40) % 8)
        0, 1, 2, 3: mix = MIX_FILL;
        4:          mix = MIX_MIXED;
        default:    mix = MIX_DRAIN;
      endcase
      gen_count++;
      roll = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:  f = (roll < 75) ? sst_pkg::OP_INSERT :
                       (roll < 85) ? sst_pkg::OP_QUERY :
                       (roll < 92) ? sst_pkg::OP_ERASE : sst_pkg::OP_READ;
        MIX_MIXED: f = (roll < 35) ? sst_pkg::OP_INSERT :
                       (roll < 60) ? sst_pkg::OP_ERASE :
                       (roll < 80) ? sst_pkg::OP_QUERY : sst_pkg::OP_READ;
        default:   f = (roll < 60) ? sst_pkg::OP_ERASE :
                       (roll < 70) ? sst_pkg::OP_INSERT :
                       (roll < 85) ? sst_pkg::OP_QUERY : sst_pkg::OP_READ;
      endcase
      k = $urandom;
      r = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 8));
      if (f == sst_pkg::OP_INSERT) begin
        if (used_keys.size() == 0 || $urandom_range(0, 99) < (mix == MIX_FILL ? 70 : 30)) begin
          k = fresh_key();
          used_keys.push_back(k);
        end else begin
          k = used_keys[$urandom_range(0, used_keys.size() - 1)];
        end
      end else if (f != sst_pkg::OP_READ) begin
        if (used_keys.size() != 0 && $urandom_range(0, 99) < 75) begin
          idx = $urandom_range(0, used_keys.size() - 1);
          k = used_keys[idx];
          if (f == sst_pkg::OP_ERASE && mix == MIX_DRAIN) used_keys.delete(idx);
        end else begin
          k = fresh_key();
        end
      end
      add_req(f, k, r);
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 33;
    recv_stall_pct = 72;
    add_req(sst_pkg::OP_READ,   32'h0000_0000, 6'd0);
    add_req(sst_pkg::OP_QUERY,  32'h0000_0000, 6'd0);
    add_req(sst_pkg::OP_ERASE,  32'h0000_0005, 6'd0);
    add_req(sst_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd0);
    add_req(sst_pkg::OP_INSERT, 32'h0000_0000, 6'd0);
    add_req(sst_pkg::OP_INSERT, 32'h0000_0000, 6'd0);
    add_req(sst_pkg::OP_INSERT, 32'h8000_0000, 6'd0);
    add_req(sst_pkg::OP_INSERT, 32'h7FFF_FFFF, 6'd0);
    add_req(sst_pkg::OP_QUERY,  32'h7FFF_FFFF, 6'd0);
    add_req(sst_pkg::OP_QUERY,  32'h0000_0001, 6'd0);
    add_req(sst_pkg::OP_READ,   32'h0000_0000, 6'd0);
    add_req(sst_pkg::OP_READ,   32'h0000_0000, 6'd3);
    add_req(sst_pkg::OP_READ,   32'h0000_0000, 6'd4);
    add_req(sst_pkg::OP_READ,   32'hFFFF_FFFF, 6'd63);
    add_req(sst_pkg::OP_ERASE,  32'h8000_0000, 6'd0);
    add_req(sst_pkg::OP_ERASE,  32'h8000_0000, 6'd0);
    add_req(sst_pkg::OP_READ,   32'h0000_0000, 6'd2);
    add_req(sst_pkg::OP_INSERT, 32'h5555_5555, 6'd63);
    add_req(sst_pkg::OP_INSERT, 32'hAAAA_AAAA, 6'd0);
    add_req(sst_pkg::OP_QUERY,  32'hAAAA_AAAA, 6'd63);
    add_req(sst_pkg::OP_READ,   32'hFFFF_FFFF, 6'd1);
    add_random(230);
    wait_drained();

    send_idle_pct = 72;
    recv_stall_pct = 33;
    add_random(230);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_random(240);
    wait_drained();

    repeat (5) @(negedge clk);
    $display("%0d requests, %0d results checked; peak count %0d, %0d full drops, %0d range reads",
             n_req, n_res, peak_count, n_full, n_range);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("sorted_set_table verification clean");
    end else begin
      $display("sorted_set_table verification failed");
    end
    $finish;
  end

endmodule
